// ----- design/ffru_pkg.sv -----
// Shared types and constants for the fixed-length frame receiver.
// No dependencies; imported by the frame parser and the top level.
`default_nettype none

package ffru_pkg;

    // Frame layout and marker bytes.
    localparam int unsigned RX_W      = 8;
    localparam int unsigned CNT_W     = 4;
    localparam logic [7:0]  START_BYTE = 8'h40;
    localparam logic [7:0]  CR_BYTE    = 8'h0D;
    localparam logic [7:0]  LF_BYTE    = 8'h0A;
    localparam logic [CNT_W-1:0] FRAME_LEN = 4'd12;
    localparam logic [CNT_W-1:0] LAST_IDX  = 4'd11;
    localparam logic [CNT_W-1:0] CR_IDX    = 4'd10;

    // One unpacked frame, object class in the lowest bits.
    typedef struct packed {
        logic [15:0] box_height;
        logic [15:0] box_width;
        logic [15:0] y_pos;
        logic [15:0] x_pos;
        logic [7:0]  obj_class;
    } result_t;

    localparam int unsigned OUT_W = $bits(result_t);

    // Parser status seen by the top level.
    typedef struct packed {
        logic             receiving;
        logic [CNT_W-1:0] byte_count;
    } status_t;

endpackage

`default_nettype wire

// ----- design/ffru_parser.sv -----
// Frame parser: start-byte hunt, byte collection, trailer check and unpacking.
// Depends on ffru_pkg.
`default_nettype none

module ffru_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        rx_byte,
    output logic                   res_valid,
    output ffru_pkg::result_t      res,
    output ffru_pkg::status_t      status
);
    import ffru_pkg::*;

    logic             receiving_reg, receiving_next;
    logic [CNT_W-1:0] count_reg, count_next;
    // Frame bytes 1 to 10; byte 0 is always the start byte, byte 11 is live.
    logic [7:0]       frame_reg [1:10];

    // Next state for one byte.
    always_comb begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        res_valid      = 1'b0;
        if (step) begin
            if (!receiving_reg) begin
                if (rx_byte == START_BYTE) begin
                    receiving_next = 1'b1;
                    count_next     = 4'd1;
                end
            end else if (count_reg == '0 || count_reg >= FRAME_LEN) begin
                // Count out of range: drop the byte and go idle.
                receiving_next = 1'b0;
                count_next     = '0;
            end else if (count_reg == LAST_IDX) begin
                receiving_next = 1'b0;
                count_next     = '0;
                res_valid      = (frame_reg[CR_IDX] == CR_BYTE) && (rx_byte == LF_BYTE);
            end else begin
                count_next = count_reg + 4'd1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
        end
    end

    // Frame storage, each byte at its own slot.
    always_ff @(posedge aclk) begin
        for (int i = 1; i <= 10; i++) begin
            if (step && receiving_reg && count_reg == CNT_W'(i)) begin
                frame_reg[i] <= rx_byte;
            end
        end
    end

    // Unpack little-endian fields.
    assign res.obj_class  = frame_reg[1];
    assign res.x_pos      = {frame_reg[3], frame_reg[2]};
    assign res.y_pos      = {frame_reg[5], frame_reg[4]};
    assign res.box_width  = {frame_reg[7], frame_reg[6]};
    assign res.box_height = {frame_reg[9], frame_reg[8]};

    assign status.receiving  = receiving_reg;
    assign status.byte_count = count_reg;

endmodule

`default_nettype wire

// ----- design/fixed_frame_receiver_unpacker.sv -----
// Top level of the fixed-length frame receiver: input word register, parser,
// result register. Depends on ffru_pkg and ffru_parser.
`default_nettype none

// Takes one received byte per word on the slave stream and looks for frames of
// twelve bytes that open with '@' and close with CR LF. A good frame gives one
// word on the master stream holding class id, x, y, width and height; a frame
// with a bad trailer gives nothing. One byte is taken every cycle while s_tready
// is high. A byte is registered at its accepting edge and parsed once the
// result register can take what it makes; the result word of a good frame is
// registered from the parse of its closing byte. While a result word waits on a
// stalled master side the parser holds; the input register can take at most one
// more byte, and then s_tready stays low until the result word is taken.
module fixed_frame_receiver_unpacker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [ffru_pkg::RX_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [7:0] obj_class, [23:8] x_pos, [39:24] y_pos, [55:40] box_width,
    // [71:56] box_height
    output logic [ffru_pkg::OUT_W-1:0]      m_tdata
);
    import ffru_pkg::*;

    logic            in_valid_reg;
    logic [RX_W-1:0] in_byte_reg;
    logic            m_valid_reg;
    result_t         m_data_reg;
    logic            advance;
    logic            res_valid;
    result_t         res;
    status_t         status;

    // The held byte moves on when the result slot can take whatever it makes.
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Input word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    ffru_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_valid_reg && advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    // Result word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Idle parser holds no count; a receiving parser holds one to eleven bytes.
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.receiving |-> status.byte_count == '0)
        else $error("idle parser with nonzero byte count");

    a_recv_count: assert property (@(posedge aclk) disable iff (!aresetn)
        status.receiving |-> (status.byte_count != '0 && status.byte_count < FRAME_LEN))
        else $error("receiving parser with count out of range");

    // Input stalls only while a byte is held.
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // A new result word always comes from a parsed byte.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg && res_valid))
        else $error("result word without a parsed closing byte");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fixed_frame_receiver_unpacker: byte frames in, unpacked results out.
// A queue-fed driver and a clocked monitor with its own frame parser; depends on ffru_pkg.

module tb;
    import ffru_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1250;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned QUIET_TAIL   = 150;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef enum int {
        TRAILER_GOOD,
        TRAILER_BAD_CR,
        TRAILER_BAD_LF,
        TRAILER_BAD_BOTH
    } trailer_e;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_MARKERS
    } fill_e;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [RX_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    fixed_frame_receiver_unpacker u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Bytes waiting to be sent and frames waiting to come out.
    logic [7:0]  byte_queue[$];
    result_t     frame_results[$];

    // Shadow copy of the parser state.
    bit                 rx_busy  = 1'b0;
    logic [CNT_W-1:0]   rx_count = '0;
    logic [7:0]         rx_frame [0:11];

    bit          in_fire     = 1'b0;
    int unsigned src_gap     = 0;
    int unsigned sink_gap    = 0;
    int unsigned idle_pct    = 10;
    int unsigned cycle_count = 0;
    int unsigned bytes_total    = 0;
    int unsigned bytes_accepted = 0;
    int unsigned frame_bytes_sent = 0;
    int unsigned results_checked  = 0;
    int unsigned good_frames      = 0;
    int unsigned dropped_frames   = 0;
    int unsigned cut_frames       = 0;
    int unsigned fail_count       = 0;

    // Parse one byte; returns 1 with the unpacked frame when a good trailer closes it.
    function automatic bit parse_byte(input logic [7:0] b, output result_t res);
        res = '0;
        if (!rx_busy) begin
            if (b == START_BYTE) begin
                rx_frame[0] = b;
                rx_count    = CNT_W'(1);
                rx_busy     = 1'b1;
            end
            return 1'b0;
        end
        // A count outside the frame cannot happen, but leaves quietly if it does.
        if (rx_count == 0 || rx_count >= FRAME_LEN) begin
            rx_busy  = 1'b0;
            rx_count = '0;
            return 1'b0;
        end
        rx_frame[rx_count] = b;
        rx_count = rx_count + 1'b1;
        if (rx_count < FRAME_LEN)
            return 1'b0;
        rx_busy  = 1'b0;
        rx_count = '0;
        if (rx_frame[CR_IDX] != CR_BYTE || rx_frame[LAST_IDX] != LF_BYTE)
            return 1'b0;
        res.obj_class  = rx_frame[1];
        res.x_pos      = {rx_frame[3], rx_frame[2]};
        res.y_pos      = {rx_frame[5], rx_frame[4]};
        res.box_width  = {rx_frame[7], rx_frame[6]};
        res.box_height = {rx_frame[9], rx_frame[8]};
        return 1'b1;
    endfunction

    function automatic logic [7:0] fill_byte(input fill_e fill, input int idx);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            // Mixes the extremes with marker bytes, a start byte among them.
            FILL_MARKERS: begin
                case (idx % 5)
                    0: return 8'hFF;
                    1: return START_BYTE;
                    2: return 8'h00;
                    3: return CR_BYTE;
                    default: return LF_BYTE;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue one full twelve-byte frame with the chosen trailer.
    task automatic push_frame(input trailer_e trailer, input fill_e fill);
        logic [7:0] cr;
        logic [7:0] lf;
        cr = CR_BYTE;
        lf = LF_BYTE;
        if (trailer == TRAILER_BAD_CR || trailer == TRAILER_BAD_BOTH)
            cr = CR_BYTE ^ 8'($urandom_range(1, 255));
        if (trailer == TRAILER_BAD_LF || trailer == TRAILER_BAD_BOTH)
            lf = LF_BYTE ^ 8'($urandom_range(1, 255));
        byte_queue.push_back(START_BYTE);
        for (int i = 1; i < 10; i++)
            byte_queue.push_back(fill_byte(fill, i));
        byte_queue.push_back(cr);
        byte_queue.push_back(lf);
        frame_bytes_sent += 12;
        if (trailer == TRAILER_GOOD)
            good_frames++;
        else
            dropped_frames++;
    endtask

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Cycle counter, idle-rate changes and the run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0) begin
            case ($urandom_range(0, 2))
                0: idle_pct <= 0;
                1: idle_pct <= 10;
                default: idle_pct <= 35;
            endcase
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d of %0d bytes accepted",
                     cycle_count, bytes_accepted, bytes_total);
            $display("Verification failed");
            $finish;
        end
    end

    // Driver: feeds the byte queue and stalls the result side, both in random bursts.
    always @(negedge aclk) begin
        bit tail;
        tail = byte_queue.size() < QUIET_TAIL;
        if (aresetn) begin
            if (!s_tvalid || in_fire) begin
                if (!tail && src_gap > 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!tail && $urandom_range(0, 99) < idle_pct) begin
                    src_gap  <= $urandom_range(0, 8);
                    s_tvalid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    s_tdata  <= byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (!tail && sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!tail && $urandom_range(0, 99) < idle_pct) begin
                sink_gap <= $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: checks each result word, then predicts from the accepted input word.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        result_t pred;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (frame_results.size() == 0) begin
                note_failure($sformatf("unexpected result word %h", m_tdata));
            end else begin
                want = frame_results.pop_front();
                if (got.obj_class !== want.obj_class || got.x_pos !== want.x_pos ||
                    got.y_pos !== want.y_pos || got.box_width !== want.box_width ||
                    got.box_height !== want.box_height)
                    note_failure($sformatf(
                        "result %0d expected class %h x %h y %h w %h h %h, got %h %h %h %h %h",
                        results_checked, want.obj_class, want.x_pos, want.y_pos,
                        want.box_width, want.box_height, got.obj_class, got.x_pos,
                        got.y_pos, got.box_width, got.box_height));
                results_checked++;
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            bytes_accepted++;
            if (parse_byte(s_tdata, pred))
                frame_results.push_back(pred);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned pick;
        int unsigned len;
        fill_e       fill;

        // Directed: idle noise at both extremes, a good frame full of markers and
        // extremes with a start byte inside, and a frame with a broken CR.
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        push_frame(TRAILER_GOOD, FILL_MARKERS);
        push_frame(TRAILER_BAD_CR, FILL_ZERO);

        // Random: mostly good frames, then broken trailers, cut frames and noise.
        while (frame_bytes_sent < RANDOM_BYTES + 24) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0: fill = FILL_ZERO;
                1: fill = FILL_ONES;
                2: fill = FILL_MARKERS;
                default: fill = FILL_RANDOM;
            endcase
            if (pick < 70) begin
                push_frame(TRAILER_GOOD, fill);
            end else if (pick < 82) begin
                push_frame(trailer_e'($urandom_range(1, 3)), fill);
            end else if (pick < 90) begin
                // A cut frame swallows the start of whatever follows it.
                len = $urandom_range(1, 10);
                byte_queue.push_back(START_BYTE);
                for (int i = 0; i < len; i++)
                    byte_queue.push_back(8'($urandom_range(0, 255)));
                frame_bytes_sent += len + 1;
                cut_frames++;
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    byte_queue.push_back(8'($urandom_range(0, 255)));
            end
        end
        bytes_total = byte_queue.size();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (bytes_accepted < bytes_total)
            @(posedge aclk);
        while (frame_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes: %0d good frames, %0d bad-trailer frames, %0d cut frames.",
                 bytes_total, good_frames, dropped_frames, cut_frames);
        $display("Checked %0d result words, %0d failures.", results_checked, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ffru_pkg.sv
design/ffru_parser.sv
design/fixed_frame_receiver_unpacker.sv
dv/tb.sv
